// ===== hdl/mplm_pkg.sv =====
// shared types, constants and helpers for the multi-pattern letter matcher
// no dependencies
`timescale 1ns / 1ps

package mplm_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int ALPHABET    = 26;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int CNT_W       = NODE_W + 1;
  localparam int LETTER_W    = 5;
  localparam int CHILD_DEPTH = MAX_NODES * ALPHABET;
  localparam int CHILD_AW    = $clog2(CHILD_DEPTH);

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_SCAN    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [LETTER_W-1:0] letter;
    logic                word_end;
  } in_item_t;

  typedef struct packed {
    logic found;
    logic table_full;
  } out_item_t;

  // flat address of one child slot: node row times alphabet plus letter
  function automatic logic [CHILD_AW-1:0] child_addr(input logic [NODE_W-1:0] node,
                                                     input logic [LETTER_W-1:0] ch);
    logic [CHILD_AW-1:0] a;
    a = CHILD_AW'(node) * CHILD_AW'(ALPHABET) + CHILD_AW'(ch);
    return a;
  endfunction

endpackage

// ===== hdl/multi_pattern_letter_matcher.sv =====
// aho-corasick matcher top level: trie, failure links and scan sequencer
// depends on mplm_pkg and mplm_ram
`timescale 1ns / 1ps

// One beat in gives one beat out with the sticky found flag and the table-full
// flag. After reset the block sweeps the child table and word marks, one entry
// a cycle, before the first item is taken. The trie, failure links, word marks
// and link queue live in four rams with registered read data, driven by one
// sequencer. A dictionary letter reads its child slot and then reports (the read
// is skipped while the rest of a dropped word is skipped); a restart, an unused
// command or an out-of-range letter goes straight to the result; and a text letter
// reads the child slot of its state, follows failure links until it finds a child
// or the root, then reads the word mark. A step also waits while the previous
// result beat is held by out_stall. The first text letter after any dictionary
// change first rebuilds all failure links and word marks breadth-first.
module multi_pattern_letter_matcher (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mplm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mplm_pkg::out_item_t out_data
);

  import mplm_pkg::*;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_ADD_RD, ST_BINIT, ST_R0, ST_R0W, ST_POP, ST_POPW, ST_FT,
    ST_CH, ST_CHW, ST_WALK, ST_WALKW, ST_FN, ST_MK, ST_SC, ST_SCW, ST_SF, ST_SM,
    ST_DONE
  } state_t;

  state_t              state_r;
  logic [CHILD_AW-1:0] clr_r;
  logic [LETTER_W-1:0] ch_r;
  logic                last_r;
  logic [CNT_W-1:0]    node_count_r;
  logic [NODE_W-1:0]   ins_r, scan_r, cur_r, t_r, c_r, n_r, ft_r;
  logic [LETTER_W-1:0] i_r;
  logic [CNT_W-1:0]    head_r, tail_r;
  logic                links_r, found_r, ovf_r, skip_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  // ram ports
  logic                child_we;
  logic [CHILD_AW-1:0] child_waddr, child_raddr;
  logic [NODE_W-1:0]   child_wdata, child_rdata;
  logic                fail_we;
  logic [NODE_W-1:0]   fail_waddr, fail_wdata, fail_raddr, fail_rdata;
  logic                mark_we;
  logic [NODE_W-1:0]   mark_waddr, mark_raddr;
  logic                mark_wdata, mark_rdata;
  logic                queue_we;
  logic [NODE_W-1:0]   queue_waddr, queue_wdata, queue_raddr, queue_rdata;

  logic              accept;
  logic              add_alloc, add_drop, add_skip_now;
  logic [NODE_W-1:0] add_next;
  logic              walk_more, scan_more;
  logic [NODE_W-1:0] scan_next;
  logic              q_room;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign add_alloc    = (child_rdata == '0) && (node_count_r != CNT_W'(MAX_NODES));
  assign add_drop     = (child_rdata == '0) && (node_count_r == CNT_W'(MAX_NODES));
  assign add_next     = (child_rdata != '0) ? child_rdata : node_count_r[NODE_W-1:0];
  assign add_skip_now = add_drop;
  assign walk_more    = (n_r != '0) && (child_rdata == '0);
  assign scan_more    = (cur_r != '0) && (child_rdata == '0);
  assign scan_next    = (child_rdata != '0) ? child_rdata : cur_r;
  assign q_room       = (tail_r != CNT_W'(MAX_NODES));

  always_comb begin
    child_we    = 1'b0;
    child_waddr = child_addr(ins_r, ch_r);
    child_wdata = add_next;
    child_raddr = child_addr(ins_r, in_data.letter);
    fail_we     = 1'b0;
    fail_waddr  = c_r;
    fail_wdata  = child_rdata;
    fail_raddr  = n_r;
    mark_we     = 1'b0;
    mark_waddr  = c_r;
    mark_wdata  = 1'b1;
    mark_raddr  = child_rdata;
    queue_we    = 1'b0;
    queue_waddr = tail_r[NODE_W-1:0];
    queue_wdata = c_r;
    queue_raddr = head_r[NODE_W-1:0];
    case (state_r)
      ST_CLR: begin
        child_we    = 1'b1;
        child_waddr = clr_r;
        child_wdata = '0;
        mark_we     = (clr_r < CHILD_AW'(MAX_NODES));
        mark_waddr  = clr_r[NODE_W-1:0];
        mark_wdata  = 1'b0;
      end
      ST_ADD_RD: begin
        child_we   = add_alloc;
        mark_we    = last_r && !add_skip_now;
        mark_waddr = add_next;
      end
      ST_BINIT: begin
        fail_we    = 1'b1;
        fail_waddr = '0;
        fail_wdata = '0;
      end
      ST_R0: child_raddr = child_addr('0, i_r);
      ST_R0W: begin
        fail_we     = (child_rdata != '0) && q_room;
        fail_waddr  = child_rdata;
        fail_wdata  = '0;
        queue_we    = (child_rdata != '0) && q_room;
        queue_wdata = child_rdata;
      end
      ST_POPW: fail_raddr = queue_rdata;
      ST_CH:   child_raddr = child_addr(t_r, i_r);
      ST_WALK: child_raddr = child_addr(n_r, i_r);
      ST_WALKW: begin
        fail_raddr = n_r;
        fail_we    = !walk_more;
        queue_we   = !walk_more && q_room;
      end
      ST_MK: mark_we = mark_rdata;
      ST_SC: child_raddr = child_addr(cur_r, ch_r);
      ST_SCW: begin
        fail_raddr = cur_r;
        mark_raddr = scan_next;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      clr_r        <= '0;
      node_count_r <= CNT_W'(1);
      ins_r        <= '0;
      scan_r       <= '0;
      links_r      <= 1'b0;
      found_r      <= 1'b0;
      ovf_r        <= 1'b0;
      skip_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      head_r       <= '0;
      tail_r       <= '0;
      i_r          <= '0;
    end else begin
      // in ST_DONE the result register is handled by the state itself
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLR: begin
          clr_r <= clr_r + CHILD_AW'(1);
          if (clr_r == CHILD_AW'(CHILD_DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            ch_r    <= in_data.letter;
            last_r  <= in_data.word_end;
            cur_r   <= scan_r;
            state_r <= ST_DONE;
            if (in_data.letter < LETTER_W'(ALPHABET)) begin
              if (in_data.cmd == CMD_ADD) begin
                links_r <= 1'b0;
                if (!skip_r) begin
                  state_r <= ST_ADD_RD;
                end else if (in_data.word_end) begin
                  ins_r  <= '0;
                  skip_r <= 1'b0;
                end
              end else if (in_data.cmd == CMD_SCAN) begin
                state_r <= links_r ? ST_SC : ST_BINIT;
              end
            end
            if (in_data.cmd == CMD_RESTART) begin
              scan_r  <= '0;
              found_r <= 1'b0;
            end
          end
        end
        ST_ADD_RD: begin
          if (add_alloc) begin
            node_count_r <= node_count_r + CNT_W'(1);
          end
          if (add_drop) begin
            ovf_r <= 1'b1;
          end
          if (last_r) begin
            ins_r  <= '0;
            skip_r <= 1'b0;
          end else if (add_drop) begin
            skip_r <= 1'b1;
          end else begin
            ins_r <= add_next;
          end
          state_r <= ST_DONE;
        end
        ST_BINIT: begin
          i_r     <= '0;
          head_r  <= '0;
          tail_r  <= '0;
          state_r <= ST_R0;
        end
        ST_R0: state_r <= ST_R0W;
        ST_R0W: begin
          if ((child_rdata != '0) && q_room) begin
            tail_r <= tail_r + CNT_W'(1);
          end
          i_r     <= i_r + LETTER_W'(1);
          state_r <= (i_r == LETTER_W'(ALPHABET - 1)) ? ST_POP : ST_R0;
        end
        ST_POP: begin
          if (head_r == tail_r) begin
            links_r <= 1'b1;
            state_r <= ST_SC;
          end else begin
            head_r  <= head_r + CNT_W'(1);
            state_r <= ST_POPW;
          end
        end
        ST_POPW: begin
          t_r     <= queue_rdata;
          i_r     <= '0;
          state_r <= ST_FT;
        end
        ST_FT: begin
          ft_r    <= fail_rdata;
          state_r <= ST_CH;
        end
        ST_CH: state_r <= ST_CHW;
        ST_CHW: begin
          if (child_rdata == '0) begin
            i_r     <= i_r + LETTER_W'(1);
            state_r <= (i_r == LETTER_W'(ALPHABET - 1)) ? ST_POP : ST_CH;
          end else begin
            c_r     <= child_rdata;
            n_r     <= ft_r;
            state_r <= ST_WALK;
          end
        end
        ST_WALK: state_r <= ST_WALKW;
        ST_WALKW: begin
          if (walk_more) begin
            state_r <= ST_FN;
          end else begin
            if (q_room) begin
              tail_r <= tail_r + CNT_W'(1);
            end
            state_r <= ST_MK;
          end
        end
        ST_FN: begin
          n_r     <= fail_rdata;
          state_r <= ST_WALK;
        end
        ST_MK: begin
          i_r     <= i_r + LETTER_W'(1);
          state_r <= (i_r == LETTER_W'(ALPHABET - 1)) ? ST_POP : ST_CH;
        end
        ST_SC: state_r <= ST_SCW;
        ST_SCW: begin
          if (scan_more) begin
            state_r <= ST_SF;
          end else begin
            cur_r   <= scan_next;
            scan_r  <= scan_next;
            state_r <= ST_SM;
          end
        end
        ST_SF: begin
          cur_r   <= fail_rdata;
          state_r <= ST_SC;
        end
        ST_SM: begin
          if (mark_rdata) begin
            found_r <= 1'b1;
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r           <= 1'b1;
            out_data_r.found      <= found_r;
            out_data_r.table_full <= ovf_r;
            state_r               <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  mplm_ram #(.WIDTH(NODE_W), .DEPTH(CHILD_DEPTH)) u_child (
    .clk(clk), .we(child_we), .waddr(child_waddr), .wdata(child_wdata),
    .raddr(child_raddr), .rdata(child_rdata)
  );

  mplm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fail (
    .clk(clk), .we(fail_we), .waddr(fail_waddr), .wdata(fail_wdata),
    .raddr(fail_raddr), .rdata(fail_rdata)
  );

  mplm_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_mark (
    .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
    .raddr(mark_raddr), .rdata(mark_rdata)
  );

  mplm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
    .clk(clk), .we(queue_we), .waddr(queue_waddr), .wdata(queue_wdata),
    .raddr(queue_raddr), .rdata(queue_rdata)
  );

  a_node_bound: assert property (@(posedge clk) disable iff (!rst_n)
    node_count_r <= CNT_W'(MAX_NODES))
    else $error("node count beyond table size");

  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("table full flag dropped");

  a_beat_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result beat without finished step");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != ST_IDLE)
    else $error("accepted beat not processed");

endmodule

// ===== hdl/mplm_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module mplm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/tb.sv =====
// self-checking bench for the multi-pattern letter matcher: directed rows, then random traffic
// depends on mplm_pkg and multi_pattern_letter_matcher
`timescale 1ns / 1ps

module tb;
  import mplm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    in_item_t  item;
    bit        chk;
    out_item_t want;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  multi_pattern_letter_matcher u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // shadow copy of the automaton
  int child_of [MAX_NODES][ALPHABET];
  int fail_of [MAX_NODES];
  bit mark_of [MAX_NODES];
  int bfs_q [MAX_NODES];
  int node_cnt = 1;
  int ins_node = 0;
  int scan_node = 0;
  bit links_ok = 0;
  bit found_st = 0;
  bit full_st = 0;
  bit skipping = 0;

  out_item_t flags_q [$];
  int        errors = 0;
  int        beats_in = 0;
  int        beats_out = 0;
  int        rebuilds = 0;
  int        gap_pct = 23;
  int        stall_pct = 64;
  bit        hold_go = 0;
  bit        hold_used = 0;
  int        hold_cnt = 0;

  function automatic void build_fail_links();
    int head, tail, t, n, f, c;
    head = 0;
    tail = 0;
    fail_of[0] = 0;
    for (int i = 0; i < ALPHABET; i++) begin
      c = child_of[0][i];
      if (c != 0) begin
        fail_of[c] = 0;
        bfs_q[tail] = c;
        tail++;
      end
    end
    while (head < tail) begin
      t = bfs_q[head];
      head++;
      for (int i = 0; i < ALPHABET; i++) begin
        c = child_of[t][i];
        if (c != 0) begin
          n = fail_of[t];
          while (n != 0 && child_of[n][i] == 0) n = fail_of[n];
          f = child_of[n][i];
          fail_of[c] = f;
          if (mark_of[f]) mark_of[c] = 1;
          if (tail < MAX_NODES) begin
            bfs_q[tail] = c;
            tail++;
          end
        end
      end
    end
    links_ok = 1;
    rebuilds++;
  endfunction

  function automatic out_item_t match_step(in_item_t it);
    int ch, nxt, cur;
    out_item_t r;
    ch = it.letter;
    if (it.cmd == CMD_ADD && ch < ALPHABET) begin
      if (!skipping) begin
        nxt = child_of[ins_node][ch];
        if (nxt == 0) begin
          if (node_cnt < MAX_NODES) begin
            nxt = node_cnt;
            node_cnt++;
            child_of[ins_node][ch] = nxt;
          end else begin
            full_st = 1;
            skipping = 1;
          end
        end
        if (!skipping) ins_node = nxt;
      end
      links_ok = 0;
      if (it.word_end) begin
        if (!skipping) mark_of[ins_node] = 1;
        ins_node = 0;
        skipping = 0;
      end
    end else if (it.cmd == CMD_SCAN && ch < ALPHABET) begin
      if (!links_ok) build_fail_links();
      cur = scan_node;
      while (cur != 0 && child_of[cur][ch] == 0) cur = fail_of[cur];
      if (child_of[cur][ch] != 0) cur = child_of[cur][ch];
      scan_node = cur;
      if (mark_of[cur]) found_st = 1;
    end else if (it.cmd == CMD_RESTART) begin
      scan_node = 0;
      found_st = 0;
    end
    r.found = found_st;
    r.table_full = full_st;
    return r;
  endfunction

  function automatic in_item_t beat(logic [1:0] cmd, int letter, bit last);
    in_item_t it;
    it.cmd = cmd;
    it.letter = letter[LETTER_W-1:0];
    it.word_end = last;
    return it;
  endfunction

  function automatic row_t mk_row(logic [1:0] cmd, int letter, bit last, bit chk = 0,
                                  bit fnd = 0, bit full = 0);
    row_t r;
    r.item = beat(cmd, letter, last);
    r.chk = chk;
    r.want.found = fnd;
    r.want.table_full = full;
    return r;
  endfunction

  task automatic offer(in_item_t it, bit chk = 0, out_item_t want = '0);
    out_item_t p;
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    p = match_step(it);
    flags_q.push_back(chk ? want : p);
    beats_in++;
  endtask

  task automatic add_word(int len, int top);
    for (int i = 0; i < len; i++)
      offer(beat(CMD_ADD, $urandom_range(top), i == len - 1));
  endtask

  // result side: check and random stall, with one long hold-off
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      beats_out++;
      if (flags_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat found=%0b table_full=%0b", $realtime,
                 out_data.found, out_data.table_full);
      end else begin
        out_item_t e;
        e = flags_q.pop_front();
        if (out_data.found !== e.found) begin
          errors++;
          $display("%0t: found expected %0b actual %0b", $realtime, e.found, out_data.found);
        end
        if (out_data.table_full !== e.table_full) begin
          errors++;
          $display("%0t: table_full expected %0b actual %0b", $realtime, e.table_full,
                   out_data.table_full);
        end
      end
    end
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    row_t rows [$];
    int r, guard;
    bit paused;
    for (int n = 0; n < MAX_NODES; n++) begin
      mark_of[n] = 0;
      fail_of[n] = 0;
      for (int l = 0; l < ALPHABET; l++) child_of[n][l] = 0;
    end

    // a=0 b=1 c=2 d=3 z=25
    rows.push_back(mk_row(CMD_SCAN, 0, 0, 1, 0, 0));      // scan on empty dictionary
    rows.push_back(mk_row(CMD_UNUSED, 31, 1, 1, 0, 0));
    rows.push_back(mk_row(CMD_ADD, 31, 1, 1, 0, 0));      // letter out of range
    rows.push_back(mk_row(CMD_SCAN, 26, 1, 1, 0, 0));
    rows.push_back(mk_row(CMD_ADD, 1, 0));
    rows.push_back(mk_row(CMD_ADD, 2, 0));
    rows.push_back(mk_row(CMD_ADD, 3, 1));
    rows.push_back(mk_row(CMD_ADD, 2, 1));                // "c" is a suffix of "bc"
    rows.push_back(mk_row(CMD_ADD, 25, 1));
    rows.push_back(mk_row(CMD_SCAN, 1, 0));
    rows.push_back(mk_row(CMD_SCAN, 2, 0));
    rows.push_back(mk_row(CMD_SCAN, 3, 1));
    rows.push_back(mk_row(CMD_RESTART, 0, 0, 1, 0, 0));
    rows.push_back(mk_row(CMD_SCAN, 25, 0));
    rows.push_back(mk_row(CMD_SCAN, 0, 0));
    rows.push_back(mk_row(CMD_RESTART, 31, 1, 1, 0, 0));
    rows.push_back(mk_row(CMD_SCAN, 1, 0));
    rows.push_back(mk_row(CMD_ADD, 0, 1));                // dictionary change mid-scan
    rows.push_back(mk_row(CMD_SCAN, 0, 0));
    rows.push_back(mk_row(CMD_SCAN, 1, 0));
    rows.push_back(mk_row(CMD_RESTART, 0, 0, 1, 0, 0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) offer(rows[i].item, rows[i].chk, rows[i].want);

    paused = 0;
    while (beats_in < 650) begin
      if (beats_in >= 220) begin
        gap_pct = 64;
        stall_pct = 23;
      end
      if (beats_in > 150 && !hold_go) hold_go = 1;
      if (beats_in > 400 && !paused) begin
        paused = 1;
        in_valid <= 1'b0;
        while (flags_q.size() != 0) @(posedge clk);
      end
      if (beats_in >= 450) begin
        gap_pct = 0;
        stall_pct = 0;
      end
      r = $urandom_range(99);
      if (r < 8 && node_cnt < 120) begin
        add_word($urandom_range(1, 4), r < 2 ? 25 : 3);
      end else if (r < 12) begin
        offer(beat(CMD_RESTART, $urandom_range(31), 1'($urandom_range(1))));
      end else if (r < 15) begin
        if (r == 12) offer(beat(CMD_UNUSED, $urandom_range(31), 1'($urandom_range(1))));
        else offer(beat(r == 13 ? CMD_ADD : CMD_SCAN, $urandom_range(26, 31),
                        1'($urandom_range(1))));
      end else begin
        repeat ($urandom_range(10, 30))
          offer(beat(CMD_SCAN, ($urandom_range(19) == 0) ? $urandom_range(25)
                                                       : $urandom_range(3),
                      1'($urandom_range(1))));
      end
    end

    // fill the node table until several words have been dropped
    guard = 0;
    while (!full_st || guard < 3) begin
      if (full_st) guard++;
      add_word($urandom_range(6, 10), 25);
    end
    offer(beat(CMD_RESTART, 0, 0));
    repeat (40) offer(beat(CMD_SCAN, $urandom_range(25), 1'($urandom_range(1))));
    offer(beat(CMD_RESTART, 0, 0));
    repeat (20) offer(beat(CMD_SCAN, $urandom_range(25), 0));
    in_valid <= 1'b0;

    guard = 0;
    while (flags_q.size() != 0 && guard < 2000000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
    if (flags_q.size() != 0) errors++;
    $display("covered %0d beats in, %0d out, %0d trie nodes, %0d link rebuilds",
             beats_in, beats_out, node_cnt, rebuilds);
    $display("table overflow reached: %0b, long result hold-off done: %0b", full_st, hold_used);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #250ms;
    $display("timeout with %0d results outstanding", flags_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
